// ===== hw/rtl/lcts_pkg.sv =====
// shared constants and codes for the load-cell tare and scale block
package lcts_pkg;

	// field and register widths
	localparam int RAW_W            = 24;
	localparam int ADC_BITS         = 24;
	localparam int FACTOR_FRAC_BITS = 16;
	localparam int WEIGHT_FRAC_BITS = 8;
	localparam int CMD_W            = 2;
	localparam int COUNT_W          = 8;
	localparam int WEIGHT_W         = 24;
	localparam int CFG_W            = 24;
	localparam int CFG_IDX_W        = 1;
	localparam int VALUE_W          = 32;
	localparam int STATUS_W         = 3;

	// datapath widths
	localparam int SUM_W    = ADC_BITS + COUNT_W + 1;
	localparam int DIFF_W   = ADC_BITS + 1;
	localparam int DIV_W    = DIFF_W + FACTOR_FRAC_BITS + WEIGHT_FRAC_BITS;
	localparam int FACTOR_W = DIV_W + 1;
	localparam int CNT_W    = $clog2(DIV_W);

	// register reset values
	localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RST = COUNT_W'(16);
	localparam logic [WEIGHT_W-1:0] KNOWN_WEIGHT_RST = WEIGHT_W'(256);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KNOWN_WEIGHT = 1'b1;

	// commands
	localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TARE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CAL     = 2'd2;
	localparam logic [CMD_W-1:0] KIND_NONE   = 2'd0;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_WEIGHT    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ACCUM     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TARE_DONE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CAL_DONE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_FACTOR = 3'd4;

endpackage

// ===== hw/rtl/load_cell_tare_scale.sv =====
// top level of the load-cell tare and scale block
// Takes one command beat at a time (measure, tare sample or calibration sample) with a
// 24-bit two's complement ADC code and returns exactly one result beat for it. Tare and
// calibration samples are summed; the last sample of a run yields the truncated average,
// which becomes the zero offset (tare) or, after subtracting the offset and dividing by
// the known weight, the scale factor (calibration). A measure returns (code - offset) /
// factor as Q.8, truncated and clamped to 32 bits, or status "no factor" while the block
// is uncalibrated. All divisions run on one shared restoring divider that retires one
// quotient bit per cycle over a 49-bit dividend. An accumulating sample or a measure
// without a factor does not use the divider, a measure or the last tare sample takes one
// divider pass, and the last calibration sample two passes (one when the known weight is
// zero); each may also wait for the result register to drain. cmd_stall is high from the
// cycle after the command beat until the result register takes the answer.
// The result register lets a finished beat wait while the next command is taken.
// Configuration writes go straight to the registers and belong in idle periods only.
module load_cell_tare_scale (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write port
	input  logic                                   cfg_we,
	input  logic [lcts_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lcts_pkg::CFG_W-1:0]             cfg_data,
	// command channel
	input  logic                                   cmd_valid,
	output logic                                   cmd_stall,
	input  logic [lcts_pkg::CMD_W-1:0]             command,
	input  logic [lcts_pkg::RAW_W-1:0]             raw_code,
	// result channel
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic signed [lcts_pkg::VALUE_W-1:0]    value,
	output logic [lcts_pkg::STATUS_W-1:0]          status,
	output logic                                   saturated
);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_POST = 3'd3;
	localparam logic [2:0] S_PUSH = 3'd4;

	// what the running division is for
	localparam logic [1:0] OP_AVG  = 2'd0;
	localparam logic [1:0] OP_FAC  = 2'd1;
	localparam logic [1:0] OP_MEAS = 2'd2;

	localparam int ADC   = lcts_pkg::ADC_BITS;
	localparam int SUMW  = lcts_pkg::SUM_W;
	localparam int DIFW  = lcts_pkg::DIFF_W;
	localparam int DIVW  = lcts_pkg::DIV_W;
	localparam int FACW  = lcts_pkg::FACTOR_W;
	localparam int VALW  = lcts_pkg::VALUE_W;
	localparam int SHIFT = lcts_pkg::FACTOR_FRAC_BITS + lcts_pkg::WEIGHT_FRAC_BITS;

	// control and persistent state
	logic [2:0]                       state_q;
	logic [1:0]                       op_q;
	logic [lcts_pkg::CNT_W-1:0]       cnt_q;
	logic                             res_valid_q;
	logic [lcts_pkg::COUNT_W-1:0]     sample_count_q;
	logic [lcts_pkg::WEIGHT_W-1:0]    known_weight_q;
	logic [SUMW-1:0]                  sum_q;
	logic [lcts_pkg::COUNT_W-1:0]     taken_q;
	logic [lcts_pkg::CMD_W-1:0]       kind_q;
	logic [ADC-1:0]                   offset_q;
	logic [FACW-1:0]                  factor_q;

	// payload registers
	logic [lcts_pkg::CMD_W-1:0]       cmd_q;
	logic [ADC-1:0]                   raw_q;
	logic                             neg_q;
	logic [DIVW-1:0]                  dvd_q;
	logic [DIVW-1:0]                  rem_q;
	logic [DIVW-1:0]                  dsr_q;
	logic [VALW-1:0]                  pend_value_q;
	logic [lcts_pkg::STATUS_W-1:0]    pend_status_q;
	logic                             pend_sat_q;
	logic [VALW-1:0]                  value_q;
	logic [lcts_pkg::STATUS_W-1:0]    status_q;
	logic                             sat_q;

	// combinational helpers
	logic                             cmd_take;
	logic                             res_take;
	logic                             res_load;
	logic                             same_kind;
	logic [SUMW-1:0]                  raw_ext;
	logic [SUMW-1:0]                  acc_sum;
	logic [lcts_pkg::COUNT_W-1:0]     acc_taken;
	logic [lcts_pkg::COUNT_W-1:0]     count_eff;
	logic                             run_done;
	logic [SUMW-1:0]                  acc_mag;
	logic [DIFW-1:0]                  meas_diff;
	logic [DIFW-1:0]                  meas_mag;
	logic                             factor_neg;
	logic [DIVW-1:0]                  factor_mag;
	logic                             factor_zero;
	logic [ADC-1:0]                   avg;
	logic [DIFW-1:0]                  cal_diff;
	logic [DIFW-1:0]                  cal_mag;
	logic [FACW-1:0]                  fac_val;
	logic [DIVW:0]                    trial;
	logic [DIVW:0]                    trial_sub;
	logic                             trial_ge;
	logic                             pos_sat;
	logic                             neg_sat;
	logic [VALW-1:0]                  meas_value;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign res_take  = res_valid_q && !res_stall;
	// result register free this cycle
	assign res_load  = (state_q == S_PUSH) && (!res_valid_q || !res_stall);

	assign res_valid = res_valid_q;
	assign value     = value_q;
	assign status    = status_q;
	assign saturated = sat_q;

	always_comb begin
		// accumulation of a tare or calibration sample
		raw_ext   = {{(SUMW-ADC){raw_q[ADC-1]}}, raw_q};
		same_kind = (kind_q == cmd_q);
		acc_sum   = (same_kind ? sum_q : '0) + raw_ext;
		acc_taken = (same_kind ? taken_q : '0) + lcts_pkg::COUNT_W'(1);
		count_eff = (sample_count_q == '0) ? lcts_pkg::COUNT_W'(1) : sample_count_q;
		run_done  = (acc_taken >= count_eff);
		acc_mag   = acc_sum[SUMW-1] ? (~acc_sum + SUMW'(1)) : acc_sum;

		// measure numerator and factor magnitude
		meas_diff   = {raw_q[ADC-1], raw_q} - {offset_q[ADC-1], offset_q};
		meas_mag    = meas_diff[DIFW-1] ? (~meas_diff + DIFW'(1)) : meas_diff;
		factor_neg  = factor_q[FACW-1];
		factor_zero = (factor_q == '0);
		factor_mag  = factor_neg ? DIVW'(~factor_q + FACW'(1)) : factor_q[DIVW-1:0];

		// after the average division
		avg      = neg_q ? (~dvd_q[ADC-1:0] + ADC'(1)) : dvd_q[ADC-1:0];
		cal_diff = {avg[ADC-1], avg} - {offset_q[ADC-1], offset_q};
		cal_mag  = cal_diff[DIFW-1] ? (~cal_diff + DIFW'(1)) : cal_diff;
		fac_val  = neg_q ? (~{1'b0, dvd_q} + FACW'(1)) : {1'b0, dvd_q};

		// one restoring divider step
		trial     = {rem_q, dvd_q[DIVW-1]};
		trial_sub = trial - {1'b0, dsr_q};
		trial_ge  = (trial >= {1'b0, dsr_q});

		// weight quotient, truncated and clamped
		pos_sat = |dvd_q[DIVW-1:VALW-1];
		neg_sat = (|dvd_q[DIVW-1:VALW]) || (dvd_q[VALW-1] && (|dvd_q[VALW-2:0]));
		if (!neg_q && pos_sat) begin
			meas_value = {1'b0, {(VALW-1){1'b1}}};
		end else if (neg_q && neg_sat) begin
			meas_value = {1'b1, {(VALW-1){1'b0}}};
		end else if (neg_q) begin
			meas_value = ~dvd_q[VALW-1:0] + VALW'(1);
		end else begin
			meas_value = dvd_q[VALW-1:0];
		end
	end

	// control, configuration and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= OP_AVG;
			cnt_q          <= '0;
			res_valid_q    <= 1'b0;
			sample_count_q <= lcts_pkg::SAMPLE_COUNT_RST;
			known_weight_q <= lcts_pkg::KNOWN_WEIGHT_RST;
			sum_q          <= '0;
			taken_q        <= '0;
			kind_q         <= lcts_pkg::KIND_NONE;
			offset_q       <= '0;
			factor_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lcts_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data[lcts_pkg::COUNT_W-1:0];
					lcts_pkg::REG_KNOWN_WEIGHT: known_weight_q <= cfg_data[lcts_pkg::WEIGHT_W-1:0];
					default: ;
				endcase
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_take) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					cnt_q <= lcts_pkg::CNT_W'(DIVW - 1);
					case (cmd_q) inside
						lcts_pkg::CMD_TARE, lcts_pkg::CMD_CAL: begin
							if (run_done) begin
								sum_q   <= '0;
								taken_q <= '0;
								kind_q  <= lcts_pkg::KIND_NONE;
								op_q    <= OP_AVG;
								state_q <= S_DIV;
							end else begin
								sum_q   <= acc_sum;
								taken_q <= acc_taken;
								kind_q  <= cmd_q;
								state_q <= S_PUSH;
							end
						end
						default: begin
							// measure, and the unused code treated alike
							op_q    <= OP_MEAS;
							state_q <= factor_zero ? S_PUSH : S_DIV;
						end
					endcase
				end
				S_DIV: begin
					cnt_q <= cnt_q - lcts_pkg::CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					cnt_q   <= lcts_pkg::CNT_W'(DIVW - 1);
					state_q <= S_PUSH;
					if (op_q == OP_AVG) begin
						if (cmd_q == lcts_pkg::CMD_TARE) begin
							offset_q <= avg;
						end else if (known_weight_q == '0) begin
							factor_q <= '0;
						end else begin
							// second pass: factor = diff / known weight
							op_q    <= OP_FAC;
							state_q <= S_DIV;
						end
					end else if (op_q == OP_FAC) begin
						factor_q <= fac_val;
					end
				end
				S_PUSH: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath and result payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= command;
			raw_q <= raw_code[ADC-1:0];
		end

		unique case (state_q)
			S_PREP: begin
				rem_q <= '0;
				case (cmd_q) inside
					lcts_pkg::CMD_TARE, lcts_pkg::CMD_CAL: begin
						neg_q         <= acc_sum[SUMW-1];
						dvd_q         <= {{(DIVW-SUMW){1'b0}}, acc_mag};
						dsr_q         <= {{(DIVW-lcts_pkg::COUNT_W){1'b0}}, count_eff};
						pend_value_q  <= '0;
						pend_status_q <= lcts_pkg::ST_ACCUM;
						pend_sat_q    <= 1'b0;
					end
					default: begin
						neg_q         <= meas_diff[DIFW-1] ^ factor_neg;
						dvd_q         <= {meas_mag, {SHIFT{1'b0}}};
						dsr_q         <= factor_mag;
						pend_value_q  <= '0;
						pend_status_q <= lcts_pkg::ST_NO_FACTOR;
						pend_sat_q    <= 1'b0;
					end
				endcase
			end
			S_DIV: begin
				rem_q <= trial_ge ? trial_sub[DIVW-1:0] : trial[DIVW-1:0];
				dvd_q <= {dvd_q[DIVW-2:0], trial_ge};
			end
			S_POST: begin
				rem_q <= '0;
				if (op_q == OP_AVG) begin
					if (cmd_q == lcts_pkg::CMD_TARE) begin
						pend_value_q  <= {{(VALW-ADC){avg[ADC-1]}}, avg};
						pend_status_q <= lcts_pkg::ST_TARE_DONE;
					end else begin
						pend_value_q  <= {{(VALW-DIFW){cal_diff[DIFW-1]}}, cal_diff};
						pend_status_q <= lcts_pkg::ST_CAL_DONE;
						neg_q         <= cal_diff[DIFW-1];
						dvd_q         <= {cal_mag, {SHIFT{1'b0}}};
						dsr_q         <= {{(DIVW-lcts_pkg::WEIGHT_W){1'b0}}, known_weight_q};
					end
				end else if (op_q == OP_MEAS) begin
					pend_value_q  <= meas_value;
					pend_status_q <= lcts_pkg::ST_WEIGHT;
					pend_sat_q    <= neg_q ? neg_sat : pos_sat;
				end
			end
			default: ;
		endcase

		if (res_load) begin
			value_q  <= pend_value_q;
			status_q <= pend_status_q;
			sat_q    <= pend_sat_q;
		end
	end

endmodule

// ===== sim/load_cell_tare_scale_test.sv =====
// self-checking testbench for the load-cell tare and scale block
module load_cell_tare_scale_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned u64_t;

	// one result beat as the block should return it
	typedef struct packed {
		logic signed [lcts_pkg::VALUE_W-1:0] value;
		logic [lcts_pkg::STATUS_W-1:0]       status;
		logic                                saturated;
	} reading_t;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 8;
	localparam int DRAIN_WAIT   = 120;
	localparam int RANDOM_BEATS = 1500;
	localparam int GAP_MAX      = 18;
	localparam int SCALE_SHIFT  = lcts_pkg::FACTOR_FRAC_BITS + lcts_pkg::WEIGHT_FRAC_BITS;

	// the spare command code, decoded as a measure
	localparam logic [lcts_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

	localparam u64_t FACTOR_LIMIT     = (u64_t'(1) << (lcts_pkg::FACTOR_W - 1)) - 1;
	localparam u64_t WEIGHT_POS_LIMIT = 64'h7FFF_FFFF;
	localparam u64_t WEIGHT_NEG_LIMIT = 64'h8000_0000;

	// block inputs, all known from time zero, reset held from the start
	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [lcts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lcts_pkg::CFG_W-1:0]      cfg_data  = '0;
	logic                            cmd_valid = 1'b0;
	logic [lcts_pkg::CMD_W-1:0]      command   = lcts_pkg::CMD_MEASURE;
	logic [lcts_pkg::RAW_W-1:0]      raw_code  = '0;
	logic                            res_stall = 1'b0;

	// block outputs
	logic                                cmd_stall;
	logic                                res_valid;
	logic signed [lcts_pkg::VALUE_W-1:0] value;
	logic [lcts_pkg::STATUS_W-1:0]       status;
	logic                                saturated;

	// mirror of the block: registers and accumulation state
	logic [lcts_pkg::COUNT_W-1:0]  avg_count   = lcts_pkg::SAMPLE_COUNT_RST;
	logic [lcts_pkg::WEIGHT_W-1:0] ref_weight  = lcts_pkg::KNOWN_WEIGHT_RST;
	longint                        run_sum     = 0;
	logic [lcts_pkg::COUNT_W-1:0]  run_length  = '0;
	logic [lcts_pkg::CMD_W-1:0]    run_kind    = lcts_pkg::KIND_NONE;
	longint                        tare_offset = 0;
	longint                        cal_factor  = 0;

	// readings still owed by the block, oldest first
	reading_t expected_readings[$];

	// pacing of both channels
	int unsigned tx_gap_max = GAP_MAX;
	int unsigned rx_gap_max = GAP_MAX;
	int unsigned hold_ask   = 0;
	int unsigned hold_seen  = 0;
	int unsigned stall_left = 0;
	int unsigned stall_draw;

	// bookkeeping
	int unsigned cycle_count = 0;
	int unsigned fail_count  = 0;
	int unsigned beats_sent  = 0;
	int unsigned n_weights   = 0;
	int unsigned n_clamped   = 0;
	int unsigned n_unscaled  = 0;
	int unsigned n_tares     = 0;
	int unsigned n_cals      = 0;
	int unsigned n_summing   = 0;
	logic        res_beat;
	reading_t    want;

	always #5 clk = ~clk;

	load_cell_tare_scale u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (command),
		.raw_code  (raw_code),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value     (value),
		.status    (status),
		.saturated (saturated)
	);

	function automatic u64_t mag64(longint v);
		return (v < 0) ? u64_t'(-v) : u64_t'(v);
	endfunction

	// works out the reading for one command beat and moves the mirror state on
	function automatic reading_t predict_reading(logic [lcts_pkg::CMD_W-1:0] cmd,
		logic [lcts_pkg::RAW_W-1:0] code);
		reading_t    r;
		longint      raw;
		longint      avg;
		longint      diff;
		u64_t        q;
		int unsigned needed;
		bit          flip;
		r = '0;
		raw = longint'($signed(code[lcts_pkg::ADC_BITS-1:0]));
		if (cmd == lcts_pkg::CMD_TARE || cmd == lcts_pkg::CMD_CAL) begin
			// a count of zero behaves as one
			needed = (avg_count == 0) ? 1 : avg_count;
			// a sample of the other kind throws the running sum away
			if (run_kind != cmd) begin
				run_sum = 0;
				run_length = '0;
				run_kind = cmd;
			end
			run_sum += raw;
			run_length += 1'b1;
			if (run_length < needed) begin
				r.status = lcts_pkg::ST_ACCUM;
			end else begin
				// average truncates toward zero
				q = mag64(run_sum) / needed;
				avg = (run_sum < 0) ? -longint'(q) : longint'(q);
				run_sum = 0;
				run_length = '0;
				run_kind = lcts_pkg::KIND_NONE;
				if (cmd == lcts_pkg::CMD_TARE) begin
					tare_offset = avg;
					r.value = lcts_pkg::VALUE_W'(avg);
					r.status = lcts_pkg::ST_TARE_DONE;
				end else begin
					diff = avg - tare_offset;
					r.value = lcts_pkg::VALUE_W'(diff);
					r.status = lcts_pkg::ST_CAL_DONE;
					if (ref_weight == 0) begin
						cal_factor = 0;
					end else begin
						q = (mag64(diff) << SCALE_SHIFT) / ref_weight;
						if (q > FACTOR_LIMIT)
							q = FACTOR_LIMIT;
						cal_factor = (diff < 0) ? -longint'(q) : longint'(q);
					end
				end
			end
		end else if (cal_factor == 0) begin
			// uncalibrated: measure (or the spare code) answers no factor
			r.status = lcts_pkg::ST_NO_FACTOR;
		end else begin
			diff = raw - tare_offset;
			flip = (diff < 0) != (cal_factor < 0);
			q = (mag64(diff) << SCALE_SHIFT) / mag64(cal_factor);
			if (!flip) begin
				if (q > WEIGHT_POS_LIMIT) begin
					q = WEIGHT_POS_LIMIT;
					r.saturated = 1'b1;
				end
				r.value = lcts_pkg::VALUE_W'(q);
			end else begin
				if (q > WEIGHT_NEG_LIMIT) begin
					q = WEIGHT_NEG_LIMIT;
					r.saturated = 1'b1;
				end
				r.value = lcts_pkg::VALUE_W'(-longint'(q));
			end
			r.status = lcts_pkg::ST_WEIGHT;
		end
		return r;
	endfunction

	// a code scattered around a level, wrapping at the adc width
	function automatic logic [lcts_pkg::RAW_W-1:0] near_code(longint centre,
		int unsigned spread);
		return lcts_pkg::RAW_W'(centre + longint'($urandom_range(0, 2 * spread))
			- longint'(spread));
	endfunction

	// samples for one run: mostly complete, now and then cut short
	function automatic int unsigned run_beats();
		int unsigned needed;
		needed = (avg_count == 0) ? 1 : avg_count;
		if ($urandom_range(0, 6) == 0)
			return $urandom_range(1, needed);
		return needed;
	endfunction

	// offer one command beat after a random gap and hold it until taken
	task automatic send_beat(logic [lcts_pkg::CMD_W-1:0] cmd, logic [lcts_pkg::RAW_W-1:0] code);
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		// valid only drops when there is a real gap, never within one step
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= cmd;
		raw_code  <= code;
		do @(posedge clk); while (cmd_stall);
		expected_readings.push_back(predict_reading(cmd, code));
		beats_sent++;
	endtask

	// let every owed reading come back, then give the block a few spare cycles
	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register writes only happen with the block idle
	task automatic write_reg(logic [lcts_pkg::CFG_IDX_W-1:0] idx,
		logic [lcts_pkg::CFG_W-1:0] data);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lcts_pkg::REG_SAMPLE_COUNT)
			avg_count = lcts_pkg::COUNT_W'(data);
		else
			ref_weight = lcts_pkg::WEIGHT_W'(data);
	endtask

	task automatic test_no_factor();
		// straight out of reset there is no factor yet
		send_beat(lcts_pkg::CMD_MEASURE, 24'h000000);
		send_beat(CMD_SPARE, 24'hFFFFFF);
	endtask

	task automatic test_tare_rules();
		// zero count behaves as one, with the most negative code
		write_reg(lcts_pkg::REG_SAMPLE_COUNT, 24'd0);
		send_beat(lcts_pkg::CMD_TARE, 24'h800000);
		// a sum of minus one over two samples truncates to zero
		write_reg(lcts_pkg::REG_SAMPLE_COUNT, 24'd2);
		send_beat(lcts_pkg::CMD_TARE, 24'h000003);
		send_beat(lcts_pkg::CMD_TARE, 24'hFFFFFC);
		// calibration run interrupted by a tare, with a measure in the middle
		send_beat(lcts_pkg::CMD_CAL, 24'd100);
		send_beat(lcts_pkg::CMD_TARE, 24'd5);
		send_beat(lcts_pkg::CMD_MEASURE, 24'd0);
		send_beat(lcts_pkg::CMD_TARE, 24'd5);
		// long run started, then the count cut so the next sample closes it
		write_reg(lcts_pkg::REG_SAMPLE_COUNT, 24'd255);
		send_beat(lcts_pkg::CMD_TARE, 24'd20);
		send_beat(lcts_pkg::CMD_TARE, 24'd40);
		write_reg(lcts_pkg::REG_SAMPLE_COUNT, 24'd1);
		send_beat(lcts_pkg::CMD_TARE, 24'd60);
	endtask

	task automatic test_calibration();
		// unity reference weight, plain positive factor
		write_reg(lcts_pkg::REG_KNOWN_WEIGHT, 24'd256);
		send_beat(lcts_pkg::CMD_TARE, 24'd120);
		send_beat(lcts_pkg::CMD_CAL, 24'd1120);
		send_beat(lcts_pkg::CMD_MEASURE, 24'd620);
		send_beat(lcts_pkg::CMD_MEASURE, 24'h800000);
		// largest weight over a span of one gives the smallest factor, so weights clamp
		write_reg(lcts_pkg::REG_KNOWN_WEIGHT, 24'hFFFFFF);
		send_beat(lcts_pkg::CMD_CAL, 24'd121);
		send_beat(lcts_pkg::CMD_MEASURE, 24'h7FFFFF);
		send_beat(lcts_pkg::CMD_MEASURE, 24'h800000);
		// smallest weight over the widest span gives the largest factor
		write_reg(lcts_pkg::REG_KNOWN_WEIGHT, 24'd1);
		send_beat(lcts_pkg::CMD_TARE, 24'h800000);
		send_beat(lcts_pkg::CMD_CAL, 24'h7FFFFF);
		send_beat(lcts_pkg::CMD_MEASURE, 24'h000000);
		// load below the offset gives a negative factor
		send_beat(lcts_pkg::CMD_TARE, 24'h7FFFFF);
		send_beat(lcts_pkg::CMD_CAL, 24'h800000);
		send_beat(lcts_pkg::CMD_MEASURE, 24'h000000);
		// zero reference weight leaves the block without a factor
		write_reg(lcts_pkg::REG_KNOWN_WEIGHT, 24'd0);
		send_beat(lcts_pkg::CMD_CAL, 24'd5);
		send_beat(lcts_pkg::CMD_MEASURE, 24'd5);
	endtask

	task automatic test_backpressure();
		int unsigned i;
		write_reg(lcts_pkg::REG_KNOWN_WEIGHT, 24'd256);
		send_beat(lcts_pkg::CMD_CAL, 24'd0);
		drain();
		// receiver sits on its stall while beats keep coming back to back
		hold_ask <= hold_ask + 1;
		tx_gap_max = 0;
		for (i = 0; i < 12; i++)
			send_beat(lcts_pkg::CMD_MEASURE, lcts_pkg::RAW_W'($urandom));
		tx_gap_max = GAP_MAX;
	endtask

	task automatic test_random_mix(int unsigned target);
		int unsigned start;
		int unsigned pick;
		int unsigned n;
		int unsigned i;
		int unsigned spread;
		longint      level;
		start = beats_sent;
		while (beats_sent - start < target) begin
			// some phases run flat out on one side or both
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
			rx_gap_max <= ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
			spread = 1 << $urandom_range(0, 16);
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				// new setting, possibly in the middle of a run
				pick = $urandom_range(0, 29);
				if ($urandom_range(0, 1) == 0)
					write_reg(lcts_pkg::REG_SAMPLE_COUNT, (pick == 0) ? 24'd0 :
						(pick == 1) ? 24'd255 : lcts_pkg::CFG_W'($urandom_range(1, 6)));
				else
					write_reg(lcts_pkg::REG_KNOWN_WEIGHT, (pick < 2) ? 24'd0 :
						(pick < 4) ? 24'd1 : (pick < 6) ? 24'hFFFFFF :
						(pick < 12) ? lcts_pkg::CFG_W'($urandom) :
						lcts_pkg::CFG_W'($urandom_range(1, 24'h00FFFF)));
			end else if (pick < 26) begin
				// tare run around one resting level
				level = longint'($signed(lcts_pkg::RAW_W'($urandom)));
				n = run_beats();
				for (i = 0; i < n; i++)
					send_beat(lcts_pkg::CMD_TARE, near_code(level, spread));
			end else if (pick < 46) begin
				// calibration run with some load on top of the offset
				level = tare_offset + longint'($signed($urandom) >>> $urandom_range(8, 30));
				n = run_beats();
				for (i = 0; i < n; i++)
					send_beat(lcts_pkg::CMD_CAL, near_code(level, spread));
			end else if (pick < 88) begin
				// weighings, mostly near the offset, some anywhere on the scale
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++)
					send_beat(($urandom_range(0, 15) == 0) ? CMD_SPARE : lcts_pkg::CMD_MEASURE,
						($urandom_range(0, 2) == 0) ? lcts_pkg::RAW_W'($urandom) :
						near_code(tare_offset, spread << 4));
			end else begin
				// noise: any command, any code
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					send_beat(lcts_pkg::CMD_W'($urandom), lcts_pkg::RAW_W'($urandom));
			end
		end
		tx_gap_max = GAP_MAX;
	endtask

	// result side: check each beat against the oldest reading, then pick the next stall
	always @(posedge clk) begin
		res_beat = arst_n && res_valid && !res_stall;
		if (res_beat) begin
			if (expected_readings.size() == 0) begin
				$error("result beat with nothing owed: value %0d status %0d", value, status);
				fail_count++;
			end else begin
				want = expected_readings.pop_front();
				if (value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, value);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (saturated !== want.saturated) begin
					$error("saturated: expected %0d, got %0d", want.saturated, saturated);
					fail_count++;
				end
				case (want.status)
					lcts_pkg::ST_WEIGHT: begin
						n_weights++;
						if (want.saturated)
							n_clamped++;
					end
					lcts_pkg::ST_ACCUM:      n_summing++;
					lcts_pkg::ST_TARE_DONE:  n_tares++;
					lcts_pkg::ST_CAL_DONE:   n_cals++;
					lcts_pkg::ST_NO_FACTOR:  n_unscaled++;
					default: ;
				endcase
			end
		end
		// a requested long hold wins over the per-beat draw
		if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			stall_left = LONG_HOLD;
			res_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			if (stall_left == 0)
				res_stall <= 1'b0;
		end else if (res_beat) begin
			stall_draw = $urandom_range(0, rx_gap_max);
			if (stall_draw != 0) begin
				stall_left = stall_draw;
				res_stall <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d readings still owed", cycle_count,
				expected_readings.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_factor();
		test_tare_rules();
		test_calibration();
		test_backpressure();
		test_random_mix(RANDOM_BEATS);
		drain();
		// room for a stray late beat to show up
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d command beats: %0d weighings (%0d clamped), %0d without a factor",
			beats_sent, n_weights, n_clamped, n_unscaled);
		$display("%0d tares and %0d calibrations completed, %0d samples summed along the way",
			n_tares, n_cals, n_summing);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== load_cell_tare_scale.f =====
hw/rtl/lcts_pkg.sv
hw/rtl/load_cell_tare_scale.sv
sim/load_cell_tare_scale_test.sv
